FILE: design/private_pair_observation_table_assert.svh
// assertion macros for the pair table
`ifndef PRIVATE_PAIR_OBSERVATION_TABLE_ASSERT_SVH
`define PRIVATE_PAIR_OBSERVATION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define PPOT_ASSERT_SAME(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

`define PPOT_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`else

`define PPOT_ASSERT_SAME(label, a, c, msg)

`define PPOT_ASSERT_NEXT(label, a, c, msg)

`endif

`endif

FILE: design/ppot_pkg.sv
package ppot_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PORT_W = 16;
  localparam int LIFE_W = 20;
  localparam int SLOT_W = 6;
  localparam int NUM_PORTS = 4;

  localparam logic [2:0] REG_PORT0 = 3'd0;
  localparam logic [2:0] REG_PORT1 = 3'd1;
  localparam logic [2:0] REG_PORT2 = 3'd2;
  localparam logic [2:0] REG_PORT3 = 3'd3;
  localparam logic [2:0] REG_LIFE  = 3'd4;

  localparam logic [LIFE_W-1:0] LIFE_RESET = 20'd20000;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic [NUM_PORTS-1:0][PORT_W-1:0] port;
    logic [LIFE_W-1:0]                life;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic pair_hit;
    logic live;
    logic older;
  } cmp_res_t;

endpackage

FILE: design/ppot_if.sv
interface ppot_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] addr_first;
  logic [31:0] addr_second;
  logic [15:0] port_src;
  logic [15:0] port_dst;
  logic [31:0] time_now;

  modport source (output valid, op, addr_first, addr_second, port_src, port_dst, time_now,
                  input ready);
  modport sink (input valid, op, addr_first, addr_second, port_src, port_dst, time_now,
                output ready);
endinterface

interface ppot_out_if;
  logic       valid;
  logic       ready;
  logic       pair_live;
  logic       noted;
  logic       refreshed;
  logic [5:0] slot;

  modport source (output valid, pair_live, noted, refreshed, slot, input ready);
  modport sink (input valid, pair_live, noted, refreshed, slot, output ready);
endinterface

FILE: design/ppot_ram.sv
module ppot_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ppot_cfg.sv
module ppot_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppot_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppot_pkg::DATA_W-1:0]  pwdata,
  output logic [ppot_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ppot_pkg::cfg_t               cfg
);

  logic [ppot_pkg::NUM_PORTS-1:0][ppot_pkg::PORT_W-1:0] port_r, port_nxt;
  logic [ppot_pkg::LIFE_W-1:0] life_r, life_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    port_nxt = port_r;
    life_nxt = life_r;
    if (wr) begin
      case (idx)
        ppot_pkg::REG_PORT0: port_nxt[0] = pwdata[ppot_pkg::PORT_W-1:0];
        ppot_pkg::REG_PORT1: port_nxt[1] = pwdata[ppot_pkg::PORT_W-1:0];
        ppot_pkg::REG_PORT2: port_nxt[2] = pwdata[ppot_pkg::PORT_W-1:0];
        ppot_pkg::REG_PORT3: port_nxt[3] = pwdata[ppot_pkg::PORT_W-1:0];
        ppot_pkg::REG_LIFE:  life_nxt    = pwdata[ppot_pkg::LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ppot_pkg::REG_PORT0: prdata = {16'd0, port_r[0]};
      ppot_pkg::REG_PORT1: prdata = {16'd0, port_r[1]};
      ppot_pkg::REG_PORT2: prdata = {16'd0, port_r[2]};
      ppot_pkg::REG_PORT3: prdata = {16'd0, port_r[3]};
      ppot_pkg::REG_LIFE:  prdata = {12'd0, life_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= '0;
      life_r <= ppot_pkg::LIFE_RESET;
    end else begin
      port_r <= port_nxt;
      life_r <= life_nxt;
    end
  end

  assign cfg.port = port_r;
  assign cfg.life = life_r;

endmodule

FILE: design/ppot_cmp.sv
module ppot_cmp (
  input  ppot_pkg::entry_t              ent,
  input  logic [31:0]                   lo,
  input  logic [31:0]                   hi,
  input  logic [31:0]                   now,
  input  logic [ppot_pkg::LIFE_W-1:0]   life,
  input  logic [31:0]                   oldest,
  output ppot_pkg::cmp_res_t            res
);

  logic [31:0] age;

  assign age          = now - ent.seen;
  assign res.pair_hit = ent.valid && (ent.lo == lo) && (ent.hi == hi);
  assign res.live     = (now >= ent.seen) && (age < {12'd0, life});
  assign res.older    = ent.seen < oldest;

endmodule

FILE: design/private_pair_observation_table.sv
// one word in flight at a time: ready only while idle, idle again as the result goes valid
// query: result goes valid via S_OUT after the one-entry-per-cycle scan of the table ram;
// qualifying observe runs the same scan, then a writeback state (S_WB) before S_OUT
// non-qualifying observe: straight from idle to S_OUT, with no scan
// the next word can be accepted in the same cycle that the result goes valid
// reset: state, counter, valids and config registers to defaults, then a clearing pass of every ram entry
`include "private_pair_observation_table_assert.svh"

module private_pair_observation_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppot_in_if.sink                      in_ch,
  ppot_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppot_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppot_pkg::DATA_W-1:0]  pwdata,
  output logic [ppot_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = IW + 1;
  localparam int EW = $bits(ppot_pkg::entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  ppot_pkg::cfg_t     cfg;
  ppot_pkg::entry_t   ent, wr_ent;
  ppot_pkg::cmp_res_t cres;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic          op_r, op_nxt;
  logic          qual_r, qual_nxt;
  logic [31:0]   lo_r, lo_nxt, hi_r, hi_nxt, now_r, now_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          vfree_r, vfree_nxt;
  logic          have_r, have_nxt;
  logic [IW-1:0] vic_idx_r, vic_idx_nxt;
  logic [31:0]   vic_time_r, vic_time_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic          out_live_r, out_live_nxt;
  logic          out_noted_r, out_noted_nxt;
  logic          out_refr_r, out_refr_nxt;
  logic [5:0]    out_slot_r, out_slot_nxt;

  logic          in_acc;
  logic          issue;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [IW-1:0] sel_idx;
  logic [IW+5:0] slot_ext;
  logic          res_noted;
  logic          qual_in;

  function automatic logic non_routable(input logic [31:0] a);
    logic [7:0] t;
    logic [7:0] n;
    t = a[31:24];
    n = a[23:16];
    return (t inside {8'd10, 8'd127, 8'd0}) || (t >= 8'd224) ||
           ((t == 8'd172) && (n inside {[8'd16:8'd31]})) ||
           ((t == 8'd192) && (n == 8'd168)) ||
           ((t == 8'd169) && (n == 8'd254)) ||
           ((t == 8'd100) && (n inside {[8'd64:8'd127]}));
  endfunction

  function automatic logic port_listed(input ppot_pkg::cfg_t c, input logic [15:0] p);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < ppot_pkg::NUM_PORTS; k++) begin
      hit = hit || ((c.port[k] != '0) && (c.port[k] == p));
    end
    return hit;
  endfunction

  ppot_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppot_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent = ram_rdata;

  ppot_cmp u_cmp (
    .ent    (ent),
    .lo     (lo_r),
    .hi     (hi_r),
    .now    (now_r),
    .life   (cfg.life),
    .oldest (vic_time_r),
    .res    (cres)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign qual_in      = (port_listed(cfg, in_ch.port_src) || port_listed(cfg, in_ch.port_dst))
                        && non_routable(in_ch.addr_first) && non_routable(in_ch.addr_second);
  assign issue        = (state_r == S_SCAN) && (cnt_r < CNT_END);

  assign wr_ent.valid = 1'b1;
  assign wr_ent.lo    = lo_r;
  assign wr_ent.hi    = hi_r;
  assign wr_ent.seen  = now_r;

  assign res_noted = (op_r == ppot_pkg::OP_OBSERVE) && qual_r;
  assign sel_idx   = found_r ? hit_idx_r : (res_noted ? vic_idx_r : '0);
  assign slot_ext  = {6'd0, sel_idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = found_r ? hit_idx_r : vic_idx_r;
    ram_wdata = wr_ent;
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[IW-1:0];
      ram_wdata = '0;
    end else if (state_r == S_WB) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ev_vld_nxt    = issue;
    ev_idx_nxt    = cnt_r[IW-1:0];
    op_nxt        = op_r;
    qual_nxt      = qual_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    now_nxt       = now_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    vfree_nxt     = vfree_r;
    have_nxt      = have_r;
    vic_idx_nxt   = vic_idx_r;
    vic_time_nxt  = vic_time_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_live_nxt  = out_live_r;
    out_noted_nxt = out_noted_r;
    out_refr_nxt  = out_refr_r;
    out_slot_nxt  = out_slot_r;

    case (state_r)
      S_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[IW-1:0] == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_ch.op;
          qual_nxt     = qual_in;
          lo_nxt       = (in_ch.addr_first < in_ch.addr_second) ? in_ch.addr_first
                                                                : in_ch.addr_second;
          hi_nxt       = (in_ch.addr_first < in_ch.addr_second) ? in_ch.addr_second
                                                                : in_ch.addr_first;
          now_nxt      = in_ch.time_now;
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          hit_idx_nxt  = '0;
          vfree_nxt    = 1'b0;
          have_nxt     = 1'b0;
          vic_idx_nxt  = '0;
          vic_time_nxt = '1;
          if ((in_ch.op == ppot_pkg::OP_QUERY) || qual_in) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (ev_vld_r && !found_r) begin
          if (op_r == ppot_pkg::OP_QUERY) begin
            if (cres.pair_hit && cres.live) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = ev_idx_r;
            end
          end else if (cres.pair_hit) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = ev_idx_r;
          end else if (ent.valid) begin
            if (!vfree_r && (!have_r || cres.older)) begin
              vic_idx_nxt  = ev_idx_r;
              vic_time_nxt = ent.seen;
              have_nxt     = 1'b1;
            end
          end else if (!vfree_r) begin
            vic_idx_nxt = ev_idx_r;
            vfree_nxt   = 1'b1;
          end
        end
        if (ev_vld_r && (ev_idx_r == LAST_IDX)) begin
          state_nxt = (op_r == ppot_pkg::OP_QUERY) ? S_OUT : S_WB;
        end
      end
      S_WB: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt   = 1'b1;
          out_live_nxt  = (op_r == ppot_pkg::OP_QUERY) && found_r;
          out_noted_nxt = res_noted;
          out_refr_nxt  = res_noted && found_r;
          out_slot_nxt  = slot_ext[5:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      ev_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ev_vld_r  <= ev_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    op_r        <= op_nxt;
    qual_r      <= qual_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    now_r       <= now_nxt;
    found_r     <= found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    vfree_r     <= vfree_nxt;
    have_r      <= have_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_time_r  <= vic_time_nxt;
    out_live_r  <= out_live_nxt;
    out_noted_r <= out_noted_nxt;
    out_refr_r  <= out_refr_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pair_live = out_live_r;
  assign out_ch.noted     = out_noted_r;
  assign out_ch.refreshed = out_refr_r;
  assign out_ch.slot      = out_slot_r;

  `PPOT_ASSERT_SAME(a_live_not_noted, out_ch.valid, !(out_ch.pair_live && out_ch.noted), "live and noted together")
  `PPOT_ASSERT_SAME(a_refresh_noted, out_ch.valid && out_ch.refreshed, out_ch.noted, "refresh without note")
  `PPOT_ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE, "idle after accept")
  `PPOT_ASSERT_SAME(a_write_phase, ram_we, (state_r == S_CLR) || (state_r == S_WB), "stray table write")

endmodule
